@@ hdl/nine_patch_stretch_map_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Nine-patch stretch map assertion macros
// Concurrent assertion shorthands shared by the nine-patch stretch map unit.
// ----------------------------------------------------------------------------
`ifndef NINE_PATCH_STRETCH_MAP_UNIT_MACROS_SVH
`define NINE_PATCH_STRETCH_MAP_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define NPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/nps_pkg.sv @@
// ----------------------------------------------------------------------------
// Nine-patch stretch map package
// Shared constants and types for the address map pipeline.
// ----------------------------------------------------------------------------
package nps_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int DIM_W      = 13;
   localparam int COORD_W    = 12;
   localparam int CSR_ADDR_W = 3;
   // Divider cells: one quotient bit per cell.
   localparam int QUO_W      = 12;
   localparam int NUM_CELLS  = QUO_W;
   // Numerator (coord - a) * sc is below 2^12 * 2^13.
   localparam int NUM_W      = 25;

   localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SRC_WIDTH     = 3'd0,
      REG_SRC_HEIGHT    = 3'd1,
      REG_DST_WIDTH     = 3'd2,
      REG_DST_HEIGHT    = 3'd3,
      REG_LEFT_MARGIN   = 3'd4,
      REG_TOP_MARGIN    = 3'd5,
      REG_RIGHT_MARGIN  = 3'd6,
      REG_BOTTOM_MARGIN = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_MAPPED = 2'd0,
      STATUS_OUTSIDE = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_MARGINS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BAND_START  = 2'd0,
      BAND_CENTRE = 2'd1,
      BAND_END    = 2'd2
   } band_type;

   // One axis of work carried along the cell chain.
   typedef struct packed {
      logic [NUM_W-1:0]   rem;      // partial remainder
      logic [DIM_W-1:0]   dc;       // divisor (destination centre)
      logic [QUO_W-1:0]   quo;      // quotient bits so far
      logic [COORD_W-1:0] base;     // value added to the quotient
      logic               direct;   // result is base alone
   } axis_work_type;

   // Per-item side information carried along the chain.
   typedef struct packed {
      logic [3:0]  region;
      status_type  status;
   } item_info_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      return (v > MAX_DIM_V) ? MAX_DIM_V : v;
   endfunction

endpackage

@@ hdl/nps_axis_prep.sv @@
// ----------------------------------------------------------------------------
// Nine-patch axis preparation
// Classifies one coordinate into a band and forms the division operands.
// ----------------------------------------------------------------------------
module nps_axis_prep (
   input  logic [nps_pkg::COORD_W-1:0] coord,
   input  logic [nps_pkg::DIM_W-1:0]   src_size,
   input  logic [nps_pkg::DIM_W-1:0]   dst_size,
   input  logic [nps_pkg::COORD_W-1:0] start_margin,
   input  logic [nps_pkg::COORD_W-1:0] end_margin,
   output nps_pkg::band_type           band,
   output logic                        empty,
   output nps_pkg::axis_work_type      work
);
   import nps_pkg::*;

   logic [DIM_W:0]     sum_m;
   logic [DIM_W-1:0]   sc;
   logic [DIM_W-1:0]   dc;
   logic [DIM_W-1:0]   end_start;
   logic [DIM_W-1:0]   off;
   logic [DIM_W-1:0]   end_val;

   // Centre extents; the caller has checked the margins fit.
   always_comb begin
      sum_m     = {2'b00, start_margin} + {2'b00, end_margin};
      sc        = src_size - sum_m[DIM_W-1:0];
      dc        = dst_size - sum_m[DIM_W-1:0];
      end_start = dst_size - {1'b0, end_margin};
      off       = {1'b0, coord} - {1'b0, start_margin};
      end_val   = (src_size - {1'b0, end_margin}) + ({1'b0, coord} - end_start);
   end

   // Band selection and the operands for the divider chain.
   always_comb begin
      work.dc = dc;
      work.quo = '0;
      work.rem = '0;
      empty = 1'b0;
      if ({1'b0, coord} < {1'b0, start_margin}) begin
         band = BAND_START;
         work.base = coord;
         work.direct = 1'b1;
      end else if ({1'b0, coord} < end_start) begin
         band = BAND_CENTRE;
         work.base = start_margin;
         work.direct = (sc == '0);
         empty = (sc == '0);
         work.rem = NUM_W'(off[COORD_W-1:0] * sc);
      end else begin
         band = BAND_END;
         work.base = end_val[COORD_W-1:0];
         work.direct = 1'b1;
      end
   end

endmodule

@@ hdl/nps_div_cell.sv @@
// ----------------------------------------------------------------------------
// Nine-patch divider cell
// One restoring division step per cell for both axes, registered.
// ----------------------------------------------------------------------------
module nps_div_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [3:0]                bit_pos,
   input  logic                      stall,
   input  logic                      up_valid,
   input  nps_pkg::axis_work_type    up_x,
   input  nps_pkg::axis_work_type    up_y,
   input  nps_pkg::item_info_type    up_info,
   output logic                      dn_valid,
   output nps_pkg::axis_work_type    dn_x,
   output nps_pkg::axis_work_type    dn_y,
   output nps_pkg::item_info_type    dn_info
);
   import nps_pkg::*;

   logic          valid_ff;
   axis_work_type x_ff, y_ff, x_in, y_in;
   item_info_type info_ff;

   function automatic axis_work_type div_step(input axis_work_type w,
                                              input logic [3:0] pos);
      axis_work_type r;
      logic [NUM_W-1:0] trial;
      r = w;
      trial = NUM_W'({w.dc, QUO_W'(0)} >> (QUO_W - pos));
      if (w.dc != '0 && w.rem >= trial) begin
         r.rem = w.rem - trial;
         r.quo[pos] = 1'b1;
      end
      return r;
   endfunction

   // The shift amount is fixed per cell, so this is a compare and subtract.
   always_comb begin
      x_in = div_step(up_x, bit_pos);
      y_in = div_step(up_y, bit_pos);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         info_ff <= up_info;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_info  = info_ff;

endmodule

@@ hdl/nine_patch_stretch_map_unit.sv @@
// ----------------------------------------------------------------------------
// Nine-patch stretch map unit
// Maps a destination pixel to the source pixel of a nine-patch stretch.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// req       in         dest_x, dest_y
// rsp       out        source_x, source_y, region, status
// csr       in         csr_index, csr_data (register write)
//
// One beat is accepted per cycle while rsp is not stalled; each result passes
// through an input register, the chain of twelve divider cells, one quotient bit
// each, and an output register before it leaves.
// Reset clears all valid flags and restores the register defaults.
// A stall on rsp freezes the whole chain; req is ready whenever the chain
// can advance.
// ----------------------------------------------------------------------------
`include "nine_patch_stretch_map_unit_macros.svh"

module nine_patch_stretch_map_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [nps_pkg::COORD_W-1:0]    req_dest_x,
   input  logic [nps_pkg::COORD_W-1:0]    req_dest_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [nps_pkg::COORD_W-1:0]    rsp_source_x,
   output logic [nps_pkg::COORD_W-1:0]    rsp_source_y,
   output logic [3:0]                     rsp_region,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nps_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [nps_pkg::DIM_W-1:0]      csr_data
);
   import nps_pkg::*;

   logic [DIM_W-1:0]   src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [COORD_W-1:0] left_ff, top_ff, right_ff, bottom_ff;

   // Register writes.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= DIM_W'(1);
         src_h_ff <= DIM_W'(1);
         dst_w_ff <= DIM_W'(1);
         dst_h_ff <= DIM_W'(1);
         left_ff <= '0;
         top_ff <= '0;
         right_ff <= '0;
         bottom_ff <= '0;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_SRC_WIDTH: src_w_ff <= csr_data;
            REG_SRC_HEIGHT: src_h_ff <= csr_data;
            REG_DST_WIDTH: dst_w_ff <= csr_data;
            REG_DST_HEIGHT: dst_h_ff <= csr_data;
            REG_LEFT_MARGIN: left_ff <= csr_data[COORD_W-1:0];
            REG_TOP_MARGIN: top_ff <= csr_data[COORD_W-1:0];
            REG_RIGHT_MARGIN: right_ff <= csr_data[COORD_W-1:0];
            REG_BOTTOM_MARGIN: bottom_ff <= csr_data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // Chain advance control.
   logic stall;
   logic out_valid_ff;
   assign stall     = out_valid_ff && !rsp_ready;
   assign req_ready = !stall;

   // Size clamping and margin checks.
   logic [DIM_W-1:0] sw, sh, dw, dh;
   logic [DIM_W:0]   mh, mv;
   logic             margin_bad, outside;
   always_comb begin
      sw = clamp_dim(src_w_ff);
      sh = clamp_dim(src_h_ff);
      dw = clamp_dim(dst_w_ff);
      dh = clamp_dim(dst_h_ff);
      mh = {2'b00, left_ff} + {2'b00, right_ff};
      mv = {2'b00, top_ff} + {2'b00, bottom_ff};
      margin_bad = (mh > {1'b0, sw}) || (mh > {1'b0, dw})
                || (mv > {1'b0, sh}) || (mv > {1'b0, dh});
      outside = ({1'b0, req_dest_x} >= dw) || ({1'b0, req_dest_y} >= dh);
   end

   // Per-axis band classification.
   band_type      bx, by;
   logic          ex, ey;
   axis_work_type wx, wy;

   nps_axis_prep u_prep_x (
      .coord(req_dest_x), .src_size(sw), .dst_size(dw),
      .start_margin(left_ff), .end_margin(right_ff),
      .band(bx), .empty(ex), .work(wx)
   );

   nps_axis_prep u_prep_y (
      .coord(req_dest_y), .src_size(sh), .dst_size(dh),
      .start_margin(top_ff), .end_margin(bottom_ff),
      .band(by), .empty(ey), .work(wy)
   );

   // Item status and region at entry.
   item_info_type info_in;
   always_comb begin
      info_in.region = '0;
      if (margin_bad) begin
         info_in.status = STATUS_MARGINS;
      end else if (outside) begin
         info_in.status = STATUS_OUTSIDE;
      end else begin
         info_in.region = 4'({2'b00, by} * 4'd3 + {2'b00, bx});
         info_in.status = (ex || ey) ? STATUS_EMPTY : STATUS_MAPPED;
      end
   end

   // Input register ahead of the cell chain.
   logic          in_valid_ff;
   axis_work_type in_x_ff, in_y_ff;
   item_info_type in_info_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!stall) begin
         in_valid_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (!stall) begin
         in_x_ff <= wx;
         in_y_ff <= wy;
         in_info_ff <= info_in;
      end
   end

   // Divider cell chain, most significant quotient bit first.
   logic          c_valid [0:NUM_CELLS];
   axis_work_type c_x [0:NUM_CELLS];
   axis_work_type c_y [0:NUM_CELLS];
   item_info_type c_info [0:NUM_CELLS];

   assign c_valid[0] = in_valid_ff;
   assign c_x[0]     = in_x_ff;
   assign c_y[0]     = in_y_ff;
   assign c_info[0]  = in_info_ff;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      nps_div_cell u_cell (
         .clock(clock), .reset(reset),
         .bit_pos(4'(QUO_W - 1 - g)), .stall(stall),
         .up_valid(c_valid[g]), .up_x(c_x[g]), .up_y(c_y[g]), .up_info(c_info[g]),
         .dn_valid(c_valid[g+1]), .dn_x(c_x[g+1]), .dn_y(c_y[g+1]),
         .dn_info(c_info[g+1])
      );
   end

   // Result assembly and output register.
   logic [COORD_W-1:0] sx_in, sy_in;
   axis_work_type      last_x, last_y;
   item_info_type      last_info;
   logic [COORD_W-1:0] sx_ff, sy_ff;
   item_info_type      out_info_ff;

   always_comb begin
      last_x = c_x[NUM_CELLS];
      last_y = c_y[NUM_CELLS];
      last_info = c_info[NUM_CELLS];
      sx_in = last_x.direct ? last_x.base : last_x.base + last_x.quo;
      sy_in = last_y.direct ? last_y.base : last_y.base + last_y.quo;
      if (last_info.status != STATUS_MAPPED) begin
         sx_in = '0;
         sy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!stall) begin
         out_valid_ff <= c_valid[NUM_CELLS];
      end
   end
   always_ff @(posedge clock) begin
      if (!stall) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         out_info_ff <= last_info;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_source_x = sx_ff;
   assign rsp_source_y = sy_ff;
   assign rsp_region   = out_info_ff.region;
   assign rsp_status   = out_info_ff.status;

   // A non-mapped status always carries a zero address.
   `NPS_ASSERT_IMP(a_zero_addr, clock, reset,
      rsp_valid && rsp_status != STATUS_MAPPED, rsp_source_x == '0 && rsp_source_y == '0,
      "nonzero address with error status")
   // Margin and outside errors report region zero.
   `NPS_ASSERT_IMP(a_region_zero, clock, reset,
      rsp_valid && (rsp_status == STATUS_MARGINS || rsp_status == STATUS_OUTSIDE),
      rsp_region == '0, "region set on error status")
   // Region never exceeds the bottom-right band.
   `NPS_ASSERT_IMP(a_region_range, clock, reset, rsp_valid, rsp_region <= 4'd8,
      "region out of range")
   // The chain must hold still while a result is refused.
   `NPS_ASSERT_NEXT(a_hold, clock, reset, stall, $stable(c_valid[NUM_CELLS]),
      "chain moved during stall")

endmodule
